[hw/rtl/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Shared widths, request codes and stage types of the cross-correlator.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int TEMPLATE_LEN_DEF = 7;
    localparam int SAMPLE_W         = 16;
    localparam int IDX_W            = 3;
    localparam int PROD_W           = 32;
    localparam int CORR_W           = 38;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

endpackage

[hw/rtl/scc_front.sv]
// ----------------------------------------------------------------------------
// scc_front
// Template store, sample delay line, flush sequencer and tap multipliers,
// with the product register that feeds the adder tree.
// ----------------------------------------------------------------------------
module scc_front #(
    parameter int TEMPLATE_LEN = scc_pkg::TEMPLATE_LEN_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic                                      i_req_type,
    input  logic [scc_pkg::IDX_W-1:0]                 i_tmpl_index,
    input  logic signed [scc_pkg::SAMPLE_W-1:0]       i_value,
    input  logic                                      i_last_sample,
    input  logic                                      i_take,
    output scc_pkg::t_stage_ctl                       o_ctl,
    output logic signed [scc_pkg::PROD_W-1:0]         o_prod [TEMPLATE_LEN]
);

    localparam int DLY_D = (TEMPLATE_LEN > 1) ? TEMPLATE_LEN - 1 : 1;
    localparam int CNT_W = (TEMPLATE_LEN > 1) ? $clog2(TEMPLATE_LEN) : 1;

    logic signed [scc_pkg::SAMPLE_W-1:0] r_tmpl [TEMPLATE_LEN];
    logic signed [scc_pkg::SAMPLE_W-1:0] r_dly  [DLY_D];
    logic signed [scc_pkg::SAMPLE_W-1:0] win    [TEMPLATE_LEN];
    logic signed [scc_pkg::PROD_W-1:0]   n_prod [TEMPLATE_LEN];
    logic signed [scc_pkg::PROD_W-1:0]   r_prod [TEMPLATE_LEN];
    logic [CNT_W-1:0]                    r_flush_cnt;
    scc_pkg::t_stage_ctl                 r_ctl;
    logic signed [scc_pkg::SAMPLE_W-1:0] cur;
    logic                                flushing;
    logic                                s1_free;
    logic                                accept;
    logic                                do_step;
    logic                                step_last;

    assign flushing = (r_flush_cnt != '0);
    assign s1_free  = !r_ctl.valid || i_take;
    assign o_ready  = s1_free && !flushing;
    assign accept   = i_valid && o_ready;
    assign cur      = flushing ? '0 : i_value;
    assign do_step  = flushing ? s1_free : (accept && (i_req_type == scc_pkg::REQ_SAMPLE));
    assign step_last = flushing ? (r_flush_cnt == CNT_W'(1))
                                : (i_last_sample && (TEMPLATE_LEN == 1));

    // window: newest sample first, then the delay line
    always_comb begin
        win[0] = cur;
        for (int j = 1; j < TEMPLATE_LEN; j++) begin
            win[j] = r_dly[j-1];
        end
    end

    always_comb begin
        for (int k = 0; k < TEMPLATE_LEN; k++) begin
            n_prod[k] = scc_pkg::PROD_W'(r_tmpl[TEMPLATE_LEN-1-k]) * scc_pkg::PROD_W'(win[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TEMPLATE_LEN; k++) begin
                r_tmpl[k] <= '0;
            end
            for (int j = 0; j < DLY_D; j++) begin
                r_dly[j] <= '0;
            end
            r_flush_cnt <= '0;
            r_ctl       <= '0;
        end else begin
            if (accept && (i_req_type == scc_pkg::REQ_WRITE)) begin
                for (int k = 0; k < TEMPLATE_LEN; k++) begin
                    if (32'(i_tmpl_index) == k) begin
                        r_tmpl[k] <= i_value;
                    end
                end
            end
            if (do_step) begin
                for (int j = DLY_D - 1; j > 0; j--) begin
                    r_dly[j] <= r_dly[j-1];
                end
                r_dly[0] <= cur;
            end
            if (accept && (i_req_type == scc_pkg::REQ_SAMPLE) && i_last_sample) begin
                r_flush_cnt <= CNT_W'(TEMPLATE_LEN - 1);
            end else if (flushing && s1_free) begin
                r_flush_cnt <= r_flush_cnt - CNT_W'(1);
            end
            if (s1_free) begin
                r_ctl.valid <= do_step;
                r_ctl.last  <= step_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && do_step) begin
            for (int k = 0; k < TEMPLATE_LEN; k++) begin
                r_prod[k] <= n_prod[k];
            end
        end
    end

    assign o_ctl = r_ctl;

    always_comb begin
        for (int k = 0; k < TEMPLATE_LEN; k++) begin
            o_prod[k] = r_prod[k];
        end
    end

endmodule

[hw/rtl/scc_sum.sv]
// ----------------------------------------------------------------------------
// scc_sum
// Adder tree over the tap products and the result output register.
// ----------------------------------------------------------------------------
module scc_sum #(
    parameter int TEMPLATE_LEN = scc_pkg::TEMPLATE_LEN_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  scc_pkg::t_stage_ctl                   i_ctl,
    input  logic signed [scc_pkg::PROD_W-1:0]     i_prod [TEMPLATE_LEN],
    output logic                                  o_take,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [scc_pkg::CORR_W-1:0]     o_corr_value,
    output logic                                  o_last_out
);

    localparam int NL = 1 << $clog2(TEMPLATE_LEN);

    logic signed [scc_pkg::CORR_W-1:0] tree [1:2*NL-1];
    logic signed [scc_pkg::CORR_W-1:0] r_corr;
    logic                              r_valid;
    logic                              r_last;

    assign o_take = !r_valid || i_ready;

    // leaves at NL.., root at 1
    always_comb begin
        for (int i = 0; i < NL; i++) begin
            tree[NL+i] = '0;
        end
        for (int i = 0; i < TEMPLATE_LEN; i++) begin
            tree[NL+i] = scc_pkg::CORR_W'(i_prod[i]);
        end
        for (int i = NL - 1; i > 0; i--) begin
            tree[i] = tree[2*i] + tree[2*i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_ctl.valid) begin
            r_corr <= tree[1];
            r_last <= i_ctl.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_corr_value = r_corr;
    assign o_last_out   = r_last;

endmodule

[hw/rtl/streaming_cross_correlator_core.sv]
// ----------------------------------------------------------------------------
// streaming_cross_correlator_core
// A sample's result passes the product register and then the output register before it is shown with o_valid.
// Throughput: one word per cycle, template writes and samples alike, while o_ready is high.
// A sample with last set is followed by TEMPLATE_LEN-1 flush values, one per
// cycle unless stalled, from the flush sequencer; o_ready stays low during them.
// Reset clears the template store, the delay line and both stages' valid flags.
// ----------------------------------------------------------------------------
module streaming_cross_correlator_core #(
    parameter int TEMPLATE_LEN = scc_pkg::TEMPLATE_LEN_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_req_type,
    input  logic [scc_pkg::IDX_W-1:0]             i_tmpl_index,
    input  logic signed [scc_pkg::SAMPLE_W-1:0]   i_value,
    input  logic                                  i_last_sample,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [scc_pkg::CORR_W-1:0]     o_corr_value,
    output logic                                  o_last_out
);

    scc_pkg::t_stage_ctl               s1_ctl;
    logic signed [scc_pkg::PROD_W-1:0] s1_prod [TEMPLATE_LEN];
    logic                              s1_take;

    scc_front #(
        .TEMPLATE_LEN (TEMPLATE_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_tmpl_index  (i_tmpl_index),
        .i_value       (i_value),
        .i_last_sample (i_last_sample),
        .i_take        (s1_take),
        .o_ctl         (s1_ctl),
        .o_prod        (s1_prod)
    );

    scc_sum #(
        .TEMPLATE_LEN (TEMPLATE_LEN)
    ) u_sum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (s1_ctl),
        .i_prod       (s1_prod),
        .o_take       (s1_take),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_corr_value (o_corr_value),
        .o_last_out   (o_last_out)
    );

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for streaming_cross_correlator_core. A driver pushes
// template writes and sample words from a queue. An in-bench FIR model with
// reversed taps predicts every correlation lag, including the flush lags
// after a sample marked last. A monitor compares each output word with the
// oldest prediction. The random part runs in three phases, with random idling
// on both sides in the first two; in the third a long output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TLEN         = scc_pkg::TEMPLATE_LEN_DEF;
    localparam int RANDOM_WORDS = 400;
    localparam int HOLD_CYCLES  = 64;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct {
        logic                                req_type;
        logic [scc_pkg::IDX_W-1:0]           idx;
        logic signed [scc_pkg::SAMPLE_W-1:0] value;
        logic                                last;
    } t_xcorr_word;

    typedef struct {
        logic signed [scc_pkg::CORR_W-1:0] corr;
        logic                              last;
    } t_corr_lag;

    logic                                i_clk;
    logic                                i_rst_n       = 1'b0;
    logic                                i_valid       = 1'b0;
    logic                                i_req_type    = scc_pkg::REQ_WRITE;
    logic [scc_pkg::IDX_W-1:0]           i_tmpl_index  = '0;
    logic signed [scc_pkg::SAMPLE_W-1:0] i_value       = '0;
    logic                                i_last_sample = 1'b0;
    logic                                i_ready       = 1'b0;
    logic                                o_ready;
    logic                                o_valid;
    logic signed [scc_pkg::CORR_W-1:0]   o_corr_value;
    logic                                o_last_out;

    t_xcorr_word                         pending_words[$];
    t_corr_lag                           expected_lags[$];
    t_xcorr_word                         cur_word;
    t_corr_lag                           want;
    logic signed [scc_pkg::SAMPLE_W-1:0] tmpl_taps [TLEN];
    logic signed [scc_pkg::SAMPLE_W-1:0] lag_line  [TLEN];

    int src_idle_pct = 37;
    int snk_idle_pct = 48;
    int words_taken  = 0;
    int hold_at      = 32'h7fff_ffff;
    int hold_left    = 0;
    bit hold_fired   = 1'b0;
    int fail_cnt     = 0;
    int cycle_cnt    = 0;

    streaming_cross_correlator_core #(
        .TEMPLATE_LEN(TLEN)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_tmpl_index  (i_tmpl_index),
        .i_value       (i_value),
        .i_last_sample (i_last_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_corr_value  (o_corr_value),
        .o_last_out    (o_last_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one lag with cur as newest sample, then shift cur into the delay line
    function automatic logic signed [scc_pkg::CORR_W-1:0] fir_shift(
        logic signed [scc_pkg::SAMPLE_W-1:0] cur);
        longint acc;
        acc = longint'(tmpl_taps[TLEN-1]) * longint'(cur);
        for (int j = 1; j < TLEN; j++)
            acc += longint'(tmpl_taps[TLEN-1-j]) * longint'(lag_line[j-1]);
        for (int j = TLEN - 2; j > 0; j--)
            lag_line[j] = lag_line[j-1];
        if (TLEN > 1)
            lag_line[0] = cur;
        return acc[scc_pkg::CORR_W-1:0];
    endfunction

    function automatic void predict_lags(t_xcorr_word w);
        t_corr_lag r;
        if (w.req_type == scc_pkg::REQ_WRITE) begin
            if (w.idx < TLEN)
                tmpl_taps[w.idx] = w.value;
        end else begin
            r.corr = fir_shift(w.value);
            r.last = w.last && (TLEN == 1);
            expected_lags.push_back(r);
            if (w.last) begin
                for (int k = 1; k < TLEN; k++) begin
                    r.corr = fir_shift('0);
                    r.last = (k == TLEN - 1);
                    expected_lags.push_back(r);
                end
                foreach (lag_line[i])
                    lag_line[i] = '0;
            end
        end
    endfunction

    function automatic void put_word(logic rt, int idx,
                                     logic signed [scc_pkg::SAMPLE_W-1:0] v, logic last);
        t_xcorr_word w;
        w.req_type = rt;
        w.idx      = scc_pkg::IDX_W'(idx);
        w.value    = v;
        w.last     = last;
        pending_words.push_back(w);
    endfunction

    function automatic logic signed [scc_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9, 0))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return scc_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            foreach (tmpl_taps[i]) begin
                tmpl_taps[i] = '0;
                lag_line[i]  = '0;
            end
        end else begin
            if (i_valid && o_ready) begin
                predict_lags(cur_word);
                words_taken <= words_taken + 1;
            end
            if (!i_valid || o_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                    cur_word = pending_words.pop_front();
                    i_req_type    <= cur_word.req_type;
                    i_tmpl_index  <= cur_word.idx;
                    i_value       <= cur_word.value;
                    i_last_sample <= cur_word.last;
                    i_valid       <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output backpressure, with one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (!hold_fired && words_taken >= hold_at) begin
            hold_fired <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99, 0) >= snk_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_lags.size() == 0) begin
                $error("unexpected word: corr_value %0d last_out %0b", o_corr_value, o_last_out);
                fail_cnt++;
            end else begin
                want = expected_lags.pop_front();
                if (o_corr_value !== want.corr) begin
                    $error("corr_value: expected %0d, actual %0d", want.corr, o_corr_value);
                    fail_cnt++;
                end
                if (o_last_out !== want.last) begin
                    $error("last_out: expected %0b, actual %0b", want.last, o_last_out);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** streaming_cross_correlator_core: FAILED **");
            $finish;
        end
    end

    task automatic load_directed();
        put_word(scc_pkg::REQ_SAMPLE, 0, 16'sh7fff, 1'b0);
        put_word(scc_pkg::REQ_WRITE, 0, 16'sh8000, 1'b0);
        put_word(scc_pkg::REQ_WRITE, 1, 16'sh7fff, 1'b0);
        put_word(scc_pkg::REQ_WRITE, 2, 16'sh0001, 1'b0);
        put_word(scc_pkg::REQ_WRITE, 3, 16'shffff, 1'b0);
        put_word(scc_pkg::REQ_WRITE, 4, 16'sh4000, 1'b0);
        put_word(scc_pkg::REQ_WRITE, 5, 16'sh8000, 1'b0);
        put_word(scc_pkg::REQ_WRITE, 6, 16'sh7fff, 1'b0);
        // index past the template end is dropped
        put_word(scc_pkg::REQ_WRITE, TLEN, 16'sh1234, 1'b0);
        // last flag on a write is ignored
        put_word(scc_pkg::REQ_WRITE, 3, 16'sh5555, 1'b1);
        put_word(scc_pkg::REQ_SAMPLE, 0, 16'sh8000, 1'b0);
        put_word(scc_pkg::REQ_SAMPLE, 7, 16'sh8000, 1'b0);
        put_word(scc_pkg::REQ_SAMPLE, 0, 16'sh7fff, 1'b0);
        // tap update in the middle of a sequence
        put_word(scc_pkg::REQ_WRITE, 6, 16'sh8000, 1'b0);
        put_word(scc_pkg::REQ_SAMPLE, 0, 16'sh8000, 1'b0);
        put_word(scc_pkg::REQ_SAMPLE, 0, 16'sh7fff, 1'b1);
        put_word(scc_pkg::REQ_SAMPLE, 0, 16'sh8000, 1'b1);
        put_word(scc_pkg::REQ_SAMPLE, 0, 16'sh0000, 1'b1);
    endtask

    task automatic gen_random(int n);
        int                                  made;
        int                                  kind;
        int                                  len;
        logic signed [scc_pkg::SAMPLE_W-1:0] tap_ext;
        logic signed [scc_pkg::SAMPLE_W-1:0] smp_ext;
        made = 0;
        while (made < n) begin
            kind = $urandom_range(99, 0);
            if (kind < 15) begin
                len = $urandom_range(3, 1);
                repeat (len)
                    put_word(scc_pkg::REQ_WRITE, $urandom_range(7, 0), rand_sample(),
                             1'($urandom_range(1, 0)));
                made += len;
            end else if (kind < 20) begin
                // full-scale taps against full-scale samples
                tap_ext = $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
                smp_ext = $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
                for (int k = 0; k < TLEN; k++)
                    put_word(scc_pkg::REQ_WRITE, k, tap_ext, 1'b0);
                for (int k = 0; k < TLEN; k++)
                    put_word(scc_pkg::REQ_SAMPLE, $urandom_range(7, 0), smp_ext, k == TLEN - 1);
                made += 2 * TLEN;
            end else if (kind < 90) begin
                len = $urandom_range(10, 1);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(9, 0) == 0)
                        put_word(scc_pkg::REQ_WRITE, $urandom_range(TLEN - 1, 0),
                                 rand_sample(), 1'($urandom_range(1, 0)));
                    put_word(scc_pkg::REQ_SAMPLE, $urandom_range(7, 0), rand_sample(),
                             k == len - 1);
                end
                made += len;
            end else begin
                put_word(1'($urandom_range(1, 0)), $urandom_range(7, 0), rand_sample(),
                         1'($urandom_range(1, 0)));
                made++;
            end
        end
    endtask

    task automatic drain();
        do
            @(negedge i_clk);
        while (pending_words.size() != 0 || i_valid || expected_lags.size() != 0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        load_directed();
        gen_random(RANDOM_WORDS / 3);
        drain();
        src_idle_pct = 48;
        snk_idle_pct = 37;
        gen_random(RANDOM_WORDS / 3);
        drain();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_at      = words_taken + 30;
        gen_random(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("** streaming_cross_correlator_core: PASSED **");
        end else begin
            $display("** streaming_cross_correlator_core: FAILED **");
        end
        $finish;
    end

endmodule
